FILE: hdl/bec_pkg.sv
// ----------------------------------------------------------------------------
// bec_pkg
// Shared types, character codes, automaton codes and the automaton
// transition function for the binary expression calculator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bec_pkg;

   // payload widths
   localparam int CH_W     = 8;
   localparam int STATUS_W = 2;
   localparam int VALUE_W  = 32;

   // ascii codes
   localparam logic [CH_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CH_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CH_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CH_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CH_W-1:0] CHAR_STAR  = 8'h2A;
   localparam logic [CH_W-1:0] CHAR_SLASH = 8'h2F;

   // automaton states
   typedef logic [2:0] dfa_type;
   localparam dfa_type DFA_START  = 3'd0;
   localparam dfa_type DFA_LEFT   = 3'd1;
   localparam dfa_type DFA_OPER   = 3'd2;
   localparam dfa_type DFA_RIGHT  = 3'd3;
   localparam dfa_type DFA_REJECT = 3'd4;

   // character classes
   typedef logic [1:0] col_type;
   localparam col_type COL_DIGIT = 2'd0;
   localparam col_type COL_PLUS  = 2'd1;
   localparam col_type COL_OTHER = 2'd2;

   // operator codes
   typedef logic [1:0] op_type;
   localparam op_type OP_ADD = 2'd0;
   localparam op_type OP_SUB = 2'd1;
   localparam op_type OP_MUL = 2'd2;
   localparam op_type OP_DIV = 2'd3;

   // result status codes
   typedef logic [STATUS_W-1:0] status_type;
   localparam status_type STATUS_OK       = 2'd0;
   localparam status_type STATUS_BAD_CHAR = 2'd1;
   localparam status_type STATUS_NOT_EXPR = 2'd2;
   localparam status_type STATUS_DIV_ZERO = 2'd3;

   // controller to datapath commands
   typedef struct packed {
      logic take_char;
      logic start_iter;
      logic step_iter;
      logic load_out;
      logic clear;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic needs_iter;
   } stat_type;

   // automaton transition
   function automatic dfa_type bec_next_state(input dfa_type st, input col_type col);
      dfa_type nxt;
      case (st)
         DFA_START: begin
            nxt = (col == COL_DIGIT) ? DFA_LEFT : DFA_REJECT;
         end
         DFA_LEFT: begin
            nxt = (col == COL_DIGIT) ? DFA_LEFT : DFA_OPER;
         end
         DFA_OPER: begin
            nxt = (col == COL_DIGIT) ? DFA_RIGHT : DFA_REJECT;
         end
         DFA_RIGHT: begin
            nxt = (col == COL_DIGIT) ? DFA_RIGHT : DFA_REJECT;
         end
         default: begin
            nxt = DFA_REJECT;
         end
      endcase
      return nxt;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/bec_if.sv
// ----------------------------------------------------------------------------
// bec_if
// Valid/ready channel interfaces for character requests and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bec_req_if;
   logic                     valid;
   logic                     ready;
   logic [bec_pkg::CH_W-1:0] ch;
   logic                     last;

   modport source (output valid, output ch, output last, input ready);
   modport sink   (input valid, input ch, input last, output ready);
endinterface

interface bec_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [bec_pkg::STATUS_W-1:0]    status;
   logic signed [bec_pkg::VALUE_W-1:0] value;

   modport source (output valid, output status, output value, input ready);
   modport sink   (input valid, input status, input value, output ready);
endinterface

`default_nettype wire

FILE: hdl/binary_expression_calculator.sv
// ----------------------------------------------------------------------------
// binary_expression_calculator
// Evaluates "digits operator digits" expressions streamed one ASCII
// character per request, giving one status and value per expression.
// ----------------------------------------------------------------------------
//   channel   dir  handshake        payload
//   req_chan  in   valid / ready    ch[7:0], last
//   rsp_chan  out  valid / ready    status[1:0], value[31:0] signed
//
//   a character request is taken every cycle while an expression is open
//   the final character closes it: an evaluation step, then for * and / with
//   an OK status the shift-add / shift-subtract unit steps once per bit of
//   the word, and then the result register is loaded
//   requests stall during that time and while a previous result waits
//   reset is synchronous and returns the block to an empty expression
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module binary_expression_calculator #(
   parameter int WORD_WIDTH = 32
) (
   input wire          clock,
   input wire          reset,
   bec_req_if.sink     req_chan,
   bec_rsp_if.source   rsp_chan
);
   import bec_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   bec_controller #(
      .WORD_WIDTH (WORD_WIDTH)
   ) u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // decode, operands, arithmetic and result register
   bec_datapath #(
      .WORD_WIDTH (WORD_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_ch     (req_chan.ch),
      .stat       (stat),
      .rsp_status (rsp_chan.status),
      .rsp_value  (rsp_chan.value)
   );

endmodule

`default_nettype wire

FILE: hdl/bec_datapath.sv
// ----------------------------------------------------------------------------
// bec_datapath
// Character decode, automaton and operand registers, shared shift-add /
// shift-subtract unit for product and quotient, and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bec_datapath #(
   parameter int WORD_WIDTH = 32
) (
   input  wire                               clock,
   input  wire                               reset,
   input  bec_pkg::cmd_type                  cmd,
   input  wire [bec_pkg::CH_W-1:0]           req_ch,
   output bec_pkg::stat_type                 stat,
   output logic [bec_pkg::STATUS_W-1:0]      rsp_status,
   output logic signed [bec_pkg::VALUE_W-1:0] rsp_value
);
   import bec_pkg::*;

   typedef logic [WORD_WIDTH-1:0] word_type;
   typedef logic [WORD_WIDTH:0]   wide_type;

   dfa_type    dfa_ff, dfa_in;
   word_type   left_ff, left_in;
   word_type   right_ff, right_in;
   op_type     op_ff, op_in;
   logic       bad_ff, bad_in;
   wide_type   acc_ff, acc_in;
   word_type   x_ff, x_in;
   word_type   y_ff, y_in;
   logic       neg_ff, neg_in;
   status_type status_ff, status_in;
   logic [VALUE_W-1:0] value_ff, value_in;

   logic       is_digit;
   logic       char_ok;
   col_type    char_col;
   op_type     char_op;
   dfa_type    st_cur;
   dfa_type    st_next;
   word_type   digit_word;
   word_type   left_x10;
   word_type   right_x10;
   word_type   left_mag;
   word_type   right_mag;
   wide_type   acc_mul;
   wide_type   rem_sh;
   wide_type   rem_diff;
   word_type   result_word;
   status_type eval_status;
   logic [VALUE_W-1:0] value32;

   // character decode
   always_comb begin
      is_digit = (req_ch >= CHAR_ZERO) && (req_ch <= CHAR_NINE);
      char_ok  = 1'b1;
      char_col = COL_DIGIT;
      char_op  = OP_ADD;
      if (is_digit) begin
         char_col = COL_DIGIT;
      end else if (req_ch == CHAR_PLUS) begin
         char_col = COL_PLUS;
         char_op  = OP_ADD;
      end else if (req_ch == CHAR_MINUS) begin
         char_col = COL_OTHER;
         char_op  = OP_SUB;
      end else if (req_ch == CHAR_STAR) begin
         char_col = COL_OTHER;
         char_op  = OP_MUL;
      end else if (req_ch == CHAR_SLASH) begin
         char_col = COL_OTHER;
         char_op  = OP_DIV;
      end else begin
         char_ok = 1'b0;
      end
   end

   // automaton step and decimal accumulation
   assign st_cur     = (dfa_ff > DFA_REJECT) ? DFA_REJECT : dfa_ff;
   assign st_next    = bec_next_state(st_cur, char_col);
   assign digit_word = {{(WORD_WIDTH-4){1'b0}}, req_ch[3:0]};
   assign left_x10   = (left_ff << 3) + (left_ff << 1) + digit_word;
   assign right_x10  = (right_ff << 3) + (right_ff << 1) + digit_word;

   // operand magnitudes for division
   assign left_mag  = left_ff[WORD_WIDTH-1] ? (word_type'(0) - left_ff) : left_ff;
   assign right_mag = right_ff[WORD_WIDTH-1] ? (word_type'(0) - right_ff) : right_ff;

   // one bit of multiply or divide
   assign acc_mul  = acc_ff + {1'b0, (y_ff[0] ? x_ff : word_type'(0))};
   assign rem_sh   = {acc_ff[WORD_WIDTH-1:0], x_ff[WORD_WIDTH-1]};
   assign rem_diff = rem_sh - {1'b0, y_ff};

   // final status and result
   always_comb begin
      if (bad_ff) begin
         eval_status = STATUS_BAD_CHAR;
      end else if (dfa_ff != DFA_RIGHT) begin
         eval_status = STATUS_NOT_EXPR;
      end else if ((op_ff == OP_DIV) && (right_ff == word_type'(0))) begin
         eval_status = STATUS_DIV_ZERO;
      end else begin
         eval_status = STATUS_OK;
      end
      case (op_ff)
         OP_ADD:  result_word = left_ff + right_ff;
         OP_SUB:  result_word = left_ff - right_ff;
         OP_MUL:  result_word = acc_ff[WORD_WIDTH-1:0];
         OP_DIV:  result_word = neg_ff ? (word_type'(0) - x_ff) : x_ff;
         default: result_word = word_type'(0);
      endcase
   end

   assign stat.needs_iter = (eval_status == STATUS_OK) &&
                            ((op_ff == OP_MUL) || (op_ff == OP_DIV));

   // fit the result to the 32-bit value
   generate
      if (WORD_WIDTH >= VALUE_W) begin : g_trunc
         assign value32 = result_word[VALUE_W-1:0];
      end else begin : g_sext
         assign value32 = {{(VALUE_W-WORD_WIDTH){result_word[WORD_WIDTH-1]}}, result_word};
      end
   endgenerate

   // expression state next values
   always_comb begin
      dfa_in   = dfa_ff;
      left_in  = left_ff;
      right_in = right_ff;
      op_in    = op_ff;
      bad_in   = bad_ff;
      if (cmd.clear) begin
         dfa_in   = DFA_START;
         left_in  = word_type'(0);
         right_in = word_type'(0);
         op_in    = OP_ADD;
         bad_in   = 1'b0;
      end else if (cmd.take_char) begin
         if (char_ok) begin
            dfa_in = st_next;
            if (st_next == DFA_LEFT) begin
               left_in = left_x10;
            end else if (st_next == DFA_RIGHT) begin
               right_in = right_x10;
            end else if (st_next == DFA_OPER) begin
               op_in = char_op;
            end
         end else begin
            bad_in = 1'b1;
         end
      end
   end

   // iteration unit next values
   always_comb begin
      acc_in = acc_ff;
      x_in   = x_ff;
      y_in   = y_ff;
      neg_in = neg_ff;
      if (cmd.start_iter) begin
         acc_in = wide_type'(0);
         if (op_ff == OP_DIV) begin
            x_in   = left_mag;
            y_in   = right_mag;
            neg_in = left_ff[WORD_WIDTH-1] ^ right_ff[WORD_WIDTH-1];
         end else begin
            x_in   = left_ff;
            y_in   = right_ff;
            neg_in = 1'b0;
         end
      end else if (cmd.step_iter) begin
         if (op_ff == OP_DIV) begin
            if (!rem_diff[WORD_WIDTH]) begin
               acc_in = rem_diff;
               x_in   = {x_ff[WORD_WIDTH-2:0], 1'b1};
            end else begin
               acc_in = rem_sh;
               x_in   = {x_ff[WORD_WIDTH-2:0], 1'b0};
            end
         end else begin
            acc_in = {1'b0, acc_mul[WORD_WIDTH-1:0]};
            x_in   = x_ff << 1;
            y_in   = y_ff >> 1;
         end
      end
   end

   // result register next values
   always_comb begin
      status_in = status_ff;
      value_in  = value_ff;
      if (cmd.load_out) begin
         status_in = eval_status;
         value_in  = (eval_status == STATUS_OK) ? value32 : {VALUE_W{1'b0}};
      end
   end

   // expression state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dfa_ff   <= DFA_START;
         left_ff  <= word_type'(0);
         right_ff <= word_type'(0);
         op_ff    <= OP_ADD;
         bad_ff   <= 1'b0;
      end else begin
         dfa_ff   <= dfa_in;
         left_ff  <= left_in;
         right_ff <= right_in;
         op_ff    <= op_in;
         bad_ff   <= bad_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      neg_ff    <= neg_in;
      status_ff <= status_in;
      value_ff  <= value_in;
   end

   assign rsp_status = status_ff;
   assign rsp_value  = signed'(value_ff);

endmodule

`default_nettype wire

FILE: hdl/bec_controller.sv
// ----------------------------------------------------------------------------
// bec_controller
// Sequencer for the calculator: takes characters, runs the iteration
// count for multiply and divide, and hands results to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bec_controller #(
   parameter int WORD_WIDTH = 32
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   input  wire               req_last,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   input  bec_pkg::stat_type stat,
   output bec_pkg::cmd_type  cmd
);
   import bec_pkg::*;

   localparam int CNT_W = $clog2(WORD_WIDTH);

   localparam logic [1:0] ST_RUN  = 2'd0;
   localparam logic [1:0] ST_PREP = 2'd1;
   localparam logic [1:0] ST_ITER = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             req_take;
   logic             out_free;

   assign req_ready = (state_ff == ST_RUN);
   assign req_take  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      cmd.take_char  = 1'b0;
      cmd.start_iter = 1'b0;
      cmd.step_iter  = 1'b0;
      cmd.load_out   = 1'b0;
      cmd.clear      = 1'b0;
      case (state_ff)
         ST_RUN: begin
            if (req_take) begin
               cmd.take_char = 1'b1;
               if (req_last) begin
                  state_in = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            if (stat.needs_iter) begin
               cmd.start_iter = 1'b1;
               cnt_in         = CNT_W'(WORD_WIDTH - 1);
               state_in       = ST_ITER;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_ITER: begin
            cmd.step_iter = 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_EMIT;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               cmd.clear    = 1'b1;
               state_in     = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   // output valid flag
   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   // a new result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while full");

   // the final character always leads to evaluation
   a_last_to_prep: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_last) |=> (state_ff == ST_PREP))
      else $error("final character did not start evaluation");

   // iteration count runs down by one each cycle
   a_count_down: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ITER && cnt_ff != '0) |=>
         (state_ff == ST_ITER && cnt_ff == $past(cnt_ff) - CNT_W'(1)))
      else $error("iteration count out of sequence");

   // a started iteration runs the full word length
   a_start_iter: assert property (@(posedge clock) disable iff (reset)
      cmd.start_iter |=> (state_ff == ST_ITER && cnt_ff == CNT_W'(WORD_WIDTH - 1)))
      else $error("iteration started with a wrong count");
`endif

endmodule

`default_nettype wire
